### rtl/scts_pkg.sv
package scts_pkg;

  localparam int POS_W    = 16;
  localparam int LAYER_W  = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int TB_W     = 3;
  localparam int CNT_W    = 5;
  localparam int CZ_W     = 3;
  localparam int REM_W    = 4;
  localparam int CIDX_W   = 10;
  localparam int PLANE_W  = 9;

  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = POS_W / MOD_DIGIT;
  localparam int MOD_STEP_W = $clog2(MOD_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_TILE_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_Y  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_Z  = 2'd3;

  localparam logic [TB_W-1:0]  TILE_BITS_RST = 3'd4;
  localparam logic [CNT_W-1:0] CHUNKS_X_RST  = 5'd4;
  localparam logic [CNT_W-1:0] CHUNKS_Y_RST  = 5'd4;
  localparam logic [CZ_W-1:0]  CHUNKS_Z_RST  = 3'd1;

  localparam logic [CNT_W-1:0] CHUNKS_XY_MAX = 5'd16;
  localparam logic [CZ_W-1:0]  CHUNKS_Z_MAX  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POOL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_MOD  = 6'b000100,
    S_DIR  = 6'b001000,
    S_TILE = 6'b010000,
    S_DONE = 6'b100000
  } scts_state_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] cx;
    logic [REM_W-1:0] cy;
  } scts_wrap_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] rem,
                                                input logic b,
                                                input logic [CNT_W-1:0] den);
    logic [CNT_W-1:0] t;
    t = {rem, b};
    if (t >= den) t = t - den;
    return t[REM_W-1:0];
  endfunction

endpackage

### rtl/scts_ram.sv
module scts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/scts_wrap.sv
module scts_wrap
  import scts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] x_num,
  input  logic [POS_W-1:0] y_num,
  input  logic [CNT_W-1:0] x_den,
  input  logic [CNT_W-1:0] y_den,
  output scts_wrap_t       wrap
);

  logic [POS_W-1:0]      ax_r, ax_nxt;
  logic [POS_W-1:0]      ay_r, ay_nxt;
  logic [REM_W-1:0]      rx_r, rx_nxt;
  logic [REM_W-1:0]      ry_r, ry_nxt;
  logic [MOD_STEP_W-1:0] step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  always_comb begin
    ax_nxt   = ax_r;
    ay_nxt   = ay_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      ax_nxt   = x_num;
      ay_nxt   = y_num;
      rx_nxt   = '0;
      ry_nxt   = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < MOD_DIGIT; i++) begin
        rx_nxt = mod_step(rx_nxt, ax_r[POS_W-1-i], x_den);
        ry_nxt = mod_step(ry_nxt, ay_r[POS_W-1-i], y_den);
      end
      ax_nxt   = ax_r << MOD_DIGIT;
      ay_nxt   = ay_r << MOD_DIGIT;
      step_nxt = step_r + 1'b1;
      if (step_r == MOD_STEP_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
  end

  assign wrap.done = done_r;
  assign wrap.cx   = rx_r;
  assign wrap.cy   = ry_r;

endmodule

### rtl/sparse_chunked_tile_store.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   operation, x_pos, y_pos, layer, write_value
// out      output     out_valid/out_stall read_value, status
// cfg      input      cfg_we              cfg_index, cfg_data
//
// One item is in flight at a time. Each item first passes through the chunk wrap unit;
// an item that fails its index check then finishes, while a write or a read goes on to
// one directory read and, for a read of an allocated chunk, one tile memory read.
// After reset a clearing pass over max(MAX_CHUNKS, POOL_BLOCKS << (2 * MAX_TILE_BITS))
// addresses empties both memories; no input is taken meanwhile.
// A finished result waits in the output register; a stalled output holds the next
// item in its last state until the register frees.
module sparse_chunked_tile_store
  import scts_pkg::*;
#(
  parameter int MAX_CHUNKS    = 64,
  parameter int POOL_BLOCKS   = 16,
  parameter int MAX_TILE_BITS = 4,
  parameter int VALUE_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [POS_W-1:0]     in_x_pos,
  input  logic [POS_W-1:0]     in_y_pos,
  input  logic [LAYER_W-1:0]   in_layer,
  input  logic [VALUE_W-1:0]   in_write_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   out_read_value,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int OFF_W      = 2 * MAX_TILE_BITS;
  localparam int BLK_W      = POOL_BLOCKS > 1 ? $clog2(POOL_BLOCKS) : 1;
  localparam int NF_W       = $clog2(POOL_BLOCKS + 1);
  localparam int TILE_SLOTS = POOL_BLOCKS << OFF_W;
  localparam int DIR_AW     = MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1;
  localparam int TILE_AW    = TILE_SLOTS > 1 ? $clog2(TILE_SLOTS) : 1;
  localparam int CLR_LEN    = MAX_CHUNKS > TILE_SLOTS ? MAX_CHUNKS : TILE_SLOTS;
  localparam int CLR_W      = CLR_LEN > 1 ? $clog2(CLR_LEN) : 1;
  localparam int DIR_W      = BLK_W + 1;
  localparam int TILE_W     = VALUE_BITS + 1;

  scts_state_t state_r, state_nxt;

  logic [TB_W-1:0]  cfg_tb_r;
  logic [CNT_W-1:0] cfg_cx_r;
  logic [CNT_W-1:0] cfg_cy_r;
  logic [CZ_W-1:0]  cfg_cz_r;

  logic [TB_W-1:0]    tb_eff;
  logic [CNT_W-1:0]   cxn;
  logic [CNT_W-1:0]   cyn;
  logic [CNT_W-1:0]   czn_wide;
  logic [CZ_W-1:0]    czn;
  logic [PLANE_W-1:0] plane_r;

  logic [CLR_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [NF_W-1:0]           nfree_r, nfree_nxt;
  logic [DIR_AW-1:0]         dir_addr_r, dir_addr_nxt;
  logic [VALUE_BITS-1:0]     res_value_r, res_value_nxt;
  logic [STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]     out_value_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_load;

  logic                      op_r;
  logic [LAYER_W-1:0]        layer_r;
  logic [OFF_W-1:0]          off_r;
  logic [VALUE_BITS-1:0]     wv_r;

  logic                      accept;
  logic [MAX_TILE_BITS-1:0]  tmask;
  logic [OFF_W-1:0]          off_in;
  scts_wrap_t                wrap;
  logic [CIDX_W-1:0]         cidx;
  logic                      range_bad;

  logic                      dir_we, dir_re;
  logic [DIR_AW-1:0]         dir_waddr;
  logic [DIR_W-1:0]          dir_wdata, dir_rdata;
  logic                      tile_we, tile_re;
  logic [TILE_AW-1:0]        tile_waddr, tile_addr;
  logic [TILE_W-1:0]         tile_wdata, tile_rdata;
  logic                      dir_hit;
  logic [BLK_W-1:0]          dir_blk, new_blk, tile_blk;

  assign tb_eff = (cfg_tb_r == '0) ? TB_W'(1) :
                  (cfg_tb_r > TB_W'(MAX_TILE_BITS)) ? TB_W'(MAX_TILE_BITS) : cfg_tb_r;
  assign cxn      = clamp_count(cfg_cx_r, CHUNKS_XY_MAX);
  assign cyn      = clamp_count(cfg_cy_r, CHUNKS_XY_MAX);
  assign czn_wide = clamp_count(CNT_W'(cfg_cz_r), CNT_W'(CHUNKS_Z_MAX));
  assign czn      = czn_wide[CZ_W-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    for (int i = 0; i < MAX_TILE_BITS; i++) begin
      tmask[i] = (TB_W'(i) < tb_eff);
    end
    off_in = (OFF_W'(in_y_pos[MAX_TILE_BITS-1:0] & tmask) << tb_eff) |
             OFF_W'(in_x_pos[MAX_TILE_BITS-1:0] & tmask);
  end

  scts_wrap u_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .x_num (in_x_pos >> tb_eff),
    .y_num (in_y_pos >> tb_eff),
    .x_den (cxn),
    .y_den (cyn),
    .wrap  (wrap)
  );

  assign cidx = CIDX_W'(layer_r) * CIDX_W'(plane_r) + CIDX_W'(wrap.cy) * CIDX_W'(cxn) +
                CIDX_W'(wrap.cx);
  assign range_bad = (CZ_W'(layer_r) >= czn) ||
                     ((CIDX_W + 1)'(cidx) >= (CIDX_W + 1)'(MAX_CHUNKS));

  assign dir_hit   = dir_rdata[BLK_W];
  assign dir_blk   = dir_rdata[BLK_W-1:0];
  assign new_blk   = BLK_W'(nfree_r);
  assign tile_blk  = dir_hit ? dir_blk : new_blk;
  assign tile_addr = TILE_AW'({tile_blk, off_r});

  scts_ram #(.WIDTH(DIR_W), .DEPTH(MAX_CHUNKS)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (DIR_AW'(cidx)),
    .rdata (dir_rdata)
  );

  scts_ram #(.WIDTH(TILE_W), .DEPTH(TILE_SLOTS)) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (tile_wdata),
    .re    (tile_re),
    .raddr (tile_addr),
    .rdata (tile_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    nfree_nxt      = nfree_r;
    dir_addr_nxt   = dir_addr_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_load       = 1'b0;
    dir_we         = 1'b0;
    dir_re         = 1'b0;
    dir_waddr      = dir_addr_r;
    dir_wdata      = {1'b1, new_blk};
    tile_we        = 1'b0;
    tile_re        = 1'b0;
    tile_waddr     = tile_addr;
    tile_wdata     = {1'b1, wv_r};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        dir_we     = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(MAX_CHUNKS));
        dir_waddr  = DIR_AW'(clr_cnt_r);
        dir_wdata  = '0;
        tile_we    = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(TILE_SLOTS));
        tile_waddr = TILE_AW'(clr_cnt_r);
        tile_wdata = '0;
        if (clr_cnt_r == CLR_W'(CLR_LEN - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        res_value_nxt  = '0;
        res_status_nxt = STATUS_OK;
        if (in_valid) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (wrap.done) begin
          if (range_bad) begin
            res_status_nxt = STATUS_RANGE;
            state_nxt      = S_DONE;
          end else begin
            dir_re       = 1'b1;
            dir_addr_nxt = DIR_AW'(cidx);
            state_nxt    = S_DIR;
          end
        end
      end
      S_DIR: begin
        if (!op_r) begin
          if (dir_hit) begin
            tile_re   = 1'b1;
            state_nxt = S_TILE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
          if (dir_hit) begin
            tile_we = 1'b1;
          end else if (nfree_r == NF_W'(POOL_BLOCKS)) begin
            res_status_nxt = STATUS_POOL;
          end else begin
            dir_we    = 1'b1;
            tile_we   = 1'b1;
            nfree_nxt = nfree_r + 1'b1;
          end
        end
      end
      S_TILE: begin
        res_value_nxt = tile_rdata[VALUE_BITS] ? tile_rdata[VALUE_BITS-1:0] : '0;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      nfree_r     <= '0;
      out_valid_r <= 1'b0;
      cfg_tb_r    <= TILE_BITS_RST;
      cfg_cx_r    <= CHUNKS_X_RST;
      cfg_cy_r    <= CHUNKS_Y_RST;
      cfg_cz_r    <= CHUNKS_Z_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      nfree_r     <= nfree_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TILE_BITS: cfg_tb_r <= cfg_data[TB_W-1:0];
          REG_CHUNKS_X:  cfg_cx_r <= cfg_data;
          REG_CHUNKS_Y:  cfg_cy_r <= cfg_data;
          REG_CHUNKS_Z:  cfg_cz_r <= cfg_data[CZ_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    plane_r      <= PLANE_W'(cxn) * PLANE_W'(cyn);
    dir_addr_r   <= dir_addr_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (accept) begin
      op_r    <= in_operation;
      layer_r <= in_layer;
      off_r   <= off_in;
      wv_r    <= in_write_value[VALUE_BITS-1:0];
    end
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = VALUE_W'(out_value_r);
  assign out_status     = out_status_r;

endmodule

### verif/sparse_chunked_tile_store_test.sv
`timescale 1ns / 1ps

module sparse_chunked_tile_store_test;
  import scts_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int TILE_BITS_MAX = 4;
  localparam int DIR_ENTRIES   = 64;
  localparam int POOL_SIZE     = 16;
  localparam int BLOCK_TILES   = 256;
  localparam int TILE_SLOTS    = POOL_SIZE * BLOCK_TILES;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT  = 10;
  localparam int HISTORY_DEPTH = 32;

  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
  } tile_result_t;

  typedef struct {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [LAYER_W-1:0] layer;
  } tile_addr_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = 1'b0;
  logic [POS_W-1:0]     in_x_pos = '0;
  logic [POS_W-1:0]     in_y_pos = '0;
  logic [LAYER_W-1:0]   in_layer = '0;
  logic [VALUE_W-1:0]   in_write_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   out_read_value;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [TB_W-1:0]  tile_bits_cfg = TILE_BITS_RST;
  logic [CNT_W-1:0] chunks_x_cfg  = CHUNKS_X_RST;
  logic [CNT_W-1:0] chunks_y_cfg  = CHUNKS_Y_RST;
  logic [CZ_W-1:0]  chunks_z_cfg  = CHUNKS_Z_RST;

  bit                 dir_valid [DIR_ENTRIES];
  logic [3:0]         dir_block [DIR_ENTRIES];
  int                 blocks_used = 0;
  logic [VALUE_W-1:0] tile_mem [TILE_SLOTS];
  bit                 tile_set [TILE_SLOTS];

  tile_result_t pending_results [$];
  tile_result_t oldest_result;
  tile_addr_t   written_addrs [$];

  int fail_count = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 70;

  sparse_chunked_tile_store uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_layer       (in_layer),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int fit_count(input logic [CNT_W-1:0] v, input int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic void predict_tile_access(input logic op,
                                              input logic [POS_W-1:0] xp,
                                              input logic [POS_W-1:0] yp,
                                              input logic [LAYER_W-1:0] lz,
                                              input logic [VALUE_W-1:0] wv,
                                              output logic [VALUE_W-1:0] rv,
                                              output logic [STATUS_W-1:0] st);
    int tb, cxn, cyn, czn, tx, ty, cx, cy, cidx, slot;
    tb = int'(tile_bits_cfg);
    if (tb < 1) tb = 1;
    if (tb > TILE_BITS_MAX) tb = TILE_BITS_MAX;
    cxn = fit_count(chunks_x_cfg, int'(CHUNKS_XY_MAX));
    cyn = fit_count(chunks_y_cfg, int'(CHUNKS_XY_MAX));
    czn = fit_count({2'b00, chunks_z_cfg}, int'(CHUNKS_Z_MAX));
    tx = int'(xp) & ((1 << tb) - 1);
    ty = int'(yp) & ((1 << tb) - 1);
    cx = (int'(xp) >> tb) % cxn;
    cy = (int'(yp) >> tb) % cyn;
    rv = '0;
    st = STATUS_OK;
    if (int'(lz) >= czn) begin
      st = STATUS_RANGE;
    end else begin
      cidx = int'(lz) * cxn * cyn + cy * cxn + cx;
      if (cidx >= DIR_ENTRIES) begin
        st = STATUS_RANGE;
      end else if (op == OP_READ) begin
        if (dir_valid[cidx]) begin
          slot = int'(dir_block[cidx]) * BLOCK_TILES + ((ty << tb) | tx);
          if (tile_set[slot]) rv = tile_mem[slot];
        end
      end else begin
        if (!dir_valid[cidx]) begin
          if (blocks_used >= POOL_SIZE) begin
            st = STATUS_POOL;
          end else begin
            dir_valid[cidx] = 1'b1;
            dir_block[cidx] = blocks_used[3:0];
            blocks_used++;
          end
        end
        if (st == STATUS_OK) begin
          slot = int'(dir_block[cidx]) * BLOCK_TILES + ((ty << tb) | tx);
          tile_mem[slot] = wv;
          tile_set[slot] = 1'b1;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("Unexpected result transfer: value %h status %0d",
                   out_read_value, out_status);
      end else begin
        oldest_result = pending_results.pop_front();
        if (oldest_result.value !== out_read_value ||
            oldest_result.status !== out_status) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("Result mismatch: expected value %h status %0d, got value %h status %0d",
                     oldest_result.value, oldest_result.status,
                     out_read_value, out_status);
        end
      end
    end
  end

  task automatic send_tile_access(input logic op, input logic [POS_W-1:0] xp,
                                  input logic [POS_W-1:0] yp,
                                  input logic [LAYER_W-1:0] lz,
                                  input logic [VALUE_W-1:0] wv);
    tile_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_x_pos       <= xp;
    in_y_pos       <= yp;
    in_layer       <= lz;
    in_write_value <= wv;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_tile_access(op, xp, yp, lz, wv, res.value, res.status);
    pending_results.push_back(res);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TILE_BITS: tile_bits_cfg = val[TB_W-1:0];
      REG_CHUNKS_X:  chunks_x_cfg  = val;
      REG_CHUNKS_Y:  chunks_y_cfg  = val;
      REG_CHUNKS_Z:  chunks_z_cfg  = val[CZ_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [TB_W-1:0] tb, input logic [CNT_W-1:0] cx,
                              input logic [CNT_W-1:0] cy, input logic [CZ_W-1:0] cz);
    settle_block();
    write_register(REG_TILE_BITS, {2'($urandom_range(3)), tb});
    write_register(REG_CHUNKS_X, cx);
    write_register(REG_CHUNKS_Y, cy);
    write_register(REG_CHUNKS_Z, {2'($urandom_range(3)), cz});
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_geometry();
    send_tile_access(OP_READ, 16'h0000, 16'h0000, 2'd0, 32'h0);
    send_tile_access(OP_WRITE, 16'h0000, 16'h0000, 2'd0, 32'hFFFF_FFFF);
    send_tile_access(OP_READ, 16'h0040, 16'h0000, 2'd0, 32'h0);
    send_tile_access(OP_READ, 16'h0001, 16'h0000, 2'd0, 32'h0);
    send_tile_access(OP_WRITE, 16'hFFFF, 16'hFFFF, 2'd0, 32'h0000_0000);
    send_tile_access(OP_READ, 16'hFFFF, 16'hFFFF, 2'd0, 32'hFFFF_FFFF);
    send_tile_access(OP_WRITE, 16'h0010, 16'h0000, 2'd1, 32'hA5A5_A5A5);
    send_tile_access(OP_READ, 16'h0000, 16'h0000, 2'd3, 32'h0);
  endtask

  task automatic test_register_clamps();
    set_geometry(3'd0, 5'd0, 5'd0, 3'd0);
    send_tile_access(OP_READ, 16'h0000, 16'h0000, 2'd0, 32'h0);
    send_tile_access(OP_WRITE, 16'h0003, 16'h0002, 2'd0, $urandom);
    send_tile_access(OP_READ, 16'h0001, 16'h0000, 2'd0, 32'h0);
    set_geometry(3'd7, 5'd31, 5'd31, 3'd7);
    send_tile_access(OP_WRITE, 16'h0030, 16'h0000, 2'd0, $urandom);
    send_tile_access(OP_READ, 16'h0000, 16'h0000, 2'd3, 32'h0);
    send_tile_access(OP_WRITE, 16'h0000, 16'h0040, 2'd0, $urandom);
  endtask

  task automatic test_pool_exhaustion();
    int c;
    set_geometry(3'd1, 5'd8, 5'd8, 3'd1);
    for (c = 16; c < 30; c++)
      send_tile_access(OP_WRITE, 16'((c % 8) * 2), 16'((c / 8) * 2), 2'd0, $urandom);
    send_tile_access(OP_READ, 16'h0000, 16'h0004, 2'd0, 32'h0);
  endtask

  task automatic test_random_traffic(input int count);
    int seg, i, pick;
    logic op;
    tile_addr_t addr;
    for (seg = 0; seg < 3; seg++) begin
      set_geometry(3'($urandom_range(7)), 5'($urandom_range(31)),
                   5'($urandom_range(31)), 3'($urandom_range(7)));
      for (i = 0; i < count / 3; i++) begin
        if (i == count / 6) settle_block();
        op = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 55 && written_addrs.size() != 0) begin
          addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
        end else if (pick < 85) begin
          addr.x = 16'($urandom_range(63));
          addr.y = 16'($urandom_range(63));
          addr.layer = 2'($urandom_range(3));
        end else begin
          addr.x = 16'($urandom);
          addr.y = 16'($urandom);
          addr.layer = 2'($urandom_range(3));
        end
        send_tile_access(op, addr.x, addr.y, addr.layer, $urandom);
        if (op == OP_WRITE) begin
          written_addrs.push_back(addr);
          if (written_addrs.size() > HISTORY_DEPTH) void'(written_addrs.pop_front());
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_register_clamps();
    test_pool_exhaustion();
    test_random_traffic(300);
    settle_block();
    send_idle_pct = 70;
    recv_idle_pct = 24;
    test_random_traffic(300);
    settle_block();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);
    settle_block();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sparse_chunked_tile_store.f
rtl/scts_pkg.sv
rtl/scts_ram.sv
rtl/scts_wrap.sv
rtl/sparse_chunked_tile_store.sv
verif/sparse_chunked_tile_store_test.sv
